[hw/rtl/psa_pkg.sv]
// Shared constants and item types of the progressive sample averager.
package psa_pkg;

   localparam int INDEX_W  = 16;
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 26;
   localparam int LEVEL_W  = 8;
   localparam int TAKEN_W  = 11;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

   localparam int DEF_MAX_PIXELS  = 65536;
   localparam int DEF_MAX_SAMPLES = 1024;

   // Divider: one input stage, one overflow check, one stage per quotient bit.
   localparam int DIV_LAT  = LEVEL_W + 2;
   // Lane: sum register plus divider.
   localparam int LANE_LAT = DIV_LAT + 1;

   // Result queue depth; a power of two, deeper than the accept-to-queue latency.
   localparam int FIFO_DEPTH = 16;

   typedef struct packed {
      logic valid;
      logic first;
      logic drop;
   } fold_ctl_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [TAKEN_W-1:0] samples;
      logic               saturated;
   } psa_meta_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic [TAKEN_W-1:0] samples;
      logic               saturated;
   } rsp_item_type;

endpackage

[hw/rtl/progressive_sample_averager_top.sv]
// Progressive sample averager: per-pixel running average of rendered sample frames.
//
// Input channel req_*: one pixel item per handshake, three signed Q4.12 colors.
// req_tuser[0] marks the first pixel of a new sample frame, req_tuser[1] a restart
// (earlier sums dropped, this frame is sample one). The first pixel after reset
// acts as a restart. Output channel rsp_*: one result item per input item, in order,
// with the 8-bit averaged levels, the frame count and a flag for dropped frames.
// Each item passes stage A, stage B, the lane sum register, the divider and the result queue.
// Throughput: one item per cycle while req_tready is high, carried by three parallel
// color lanes, each with its own sum RAM and a fully pipelined divider; one RAM read
// and one write per lane per cycle, with same-pixel forwarding between consecutive items.
// Up to 16 items may be outstanding (accepted, result not yet taken); when the
// receiver stalls, results collect in a 16-entry queue and req_tready falls once
// 16 are outstanding. Reset clears the frame count and the queue; sums are not
// cleared and each pixel is written by the first frame after a restart, so there
// is no clearing pass and the block accepts items right after reset.
module progressive_sample_averager_top import psa_pkg::*; #(
   parameter int MAX_PIXELS  = DEF_MAX_PIXELS,
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // pixel_index, sample_red, sample_green, sample_blue
   input  logic [1:0]  req_tuser,  // frame_start, restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // out_index, red_level, green_level, blue_level,
                                   // samples_taken, zero fill
   output logic [0:0]  rsp_tuser   // saturated
);

   localparam int AW       = MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1;
   localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
   localparam int CRED_W   = $clog2(FIFO_DEPTH + 1);
   localparam int SLOT_SH  = INDEX_W + $clog2(MAX_PIXELS);
   localparam logic [63:0] SLOT_MUL_FULL =
      ((64'd1 << SLOT_SH) + 64'(MAX_PIXELS) - 64'd1) / 64'(MAX_PIXELS);
   localparam logic [17:0] SLOT_MUL = SLOT_MUL_FULL[17:0];
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

   logic                accept;
   logic                deliver;

   // Frame control.
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                first_ff;
   logic                first_in;
   logic                drop_ff;
   logic                drop_in;
   logic                open_frame;
   logic                restart_now;

   logic [CRED_W-1:0]   credit_ff;
   logic [CRED_W-1:0]   credit_in;

   // Stage A: control settled, slot product formed.
   logic                a_valid_ff;
   logic [INDEX_W-1:0]  a_index_ff;
   logic [33:0]         a_prod_ff;
   logic [SAMPLE_W-1:0] a_red_ff;
   logic [SAMPLE_W-1:0] a_green_ff;
   logic [SAMPLE_W-1:0] a_blue_ff;
   logic                a_first_ff;
   logic                a_drop_ff;
   logic [CNT_W-1:0]    a_count_ff;
   logic [INDEX_W-1:0]  a_quot;
   logic [36:0]         a_slot_wide;
   logic [AW-1:0]       a_slot;

   // Stage B: sums folded in the lanes.
   logic                b_valid_ff;
   logic [AW-1:0]       b_slot_ff;
   logic [SAMPLE_W-1:0] b_red_ff;
   logic [SAMPLE_W-1:0] b_green_ff;
   logic [SAMPLE_W-1:0] b_blue_ff;
   logic                b_first_ff;
   logic                b_drop_ff;
   logic [CNT_W-1:0]    b_count_ff;
   logic [INDEX_W-1:0]  b_index_ff;
   fold_ctl_type        b_ctl;

   psa_meta_type        meta_ff  [LANE_LAT];
   logic                mvalid_ff [LANE_LAT];
   psa_meta_type        b_meta;

   logic [LEVEL_W-1:0]  red_level;
   logic [LEVEL_W-1:0]  green_level;
   logic [LEVEL_W-1:0]  blue_level;
   rsp_item_type        out_item;

   assign accept     = req_tvalid && req_tready;
   assign deliver    = rsp_tvalid && rsp_tready;
   assign req_tready = credit_ff < CRED_W'(FIFO_DEPTH);
   assign credit_in  = credit_ff + CRED_W'(accept) - CRED_W'(deliver);

   assign restart_now = req_tuser[1] || (count_ff == '0);
   assign open_frame  = req_tuser[0] || restart_now;

   always_comb begin
      count_in = count_ff;
      first_in = first_ff;
      drop_in  = drop_ff;
      if (accept && open_frame) begin
         if (restart_now) begin
            count_in = CNT_W'(1);
            first_in = 1'b1;
            drop_in  = 1'b0;
         end else if (count_ff < CNT_MAX) begin
            count_in = count_ff + CNT_W'(1);
            first_in = 1'b0;
            drop_in  = 1'b0;
         end else begin
            // Count full: hold the count, drop this frame.
            first_in = 1'b0;
            drop_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         first_ff   <= 1'b0;
         drop_ff    <= 1'b0;
         credit_ff  <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         first_ff   <= first_in;
         drop_ff    <= drop_in;
         credit_ff  <= credit_in;
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_index_ff <= req_tdata[15:0];
      a_prod_ff  <= {18'd0, req_tdata[15:0]} * {16'd0, SLOT_MUL};
      a_red_ff   <= req_tdata[31:16];
      a_green_ff <= req_tdata[47:32];
      a_blue_ff  <= req_tdata[63:48];
      a_first_ff <= first_in;
      a_drop_ff  <= drop_in;
      a_count_ff <= count_in;
   end

   // Slot is the pixel index modulo the storage size, by reciprocal multiply.
   assign a_quot      = INDEX_W'(a_prod_ff >> SLOT_SH);
   assign a_slot_wide = {21'd0, a_index_ff} - ({21'd0, a_quot} * 37'(MAX_PIXELS));
   assign a_slot      = a_slot_wide[AW-1:0];

   always_ff @(posedge clock) begin
      b_slot_ff  <= a_slot;
      b_red_ff   <= a_red_ff;
      b_green_ff <= a_green_ff;
      b_blue_ff  <= a_blue_ff;
      b_first_ff <= a_first_ff;
      b_drop_ff  <= a_drop_ff;
      b_count_ff <= a_count_ff;
      b_index_ff <= a_index_ff;
   end

   assign b_ctl.valid = b_valid_ff;
   assign b_ctl.first = b_first_ff;
   assign b_ctl.drop  = b_drop_ff;

   psa_lane #(
      .MAX_PIXELS  (MAX_PIXELS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_lane_red (
      .clock   (clock),
      .reset   (reset),
      .rd_slot (a_slot),
      .ctl     (b_ctl),
      .wr_slot (b_slot_ff),
      .sample  (b_red_ff),
      .count   (b_count_ff),
      .level   (red_level)
   );

   psa_lane #(
      .MAX_PIXELS  (MAX_PIXELS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_lane_green (
      .clock   (clock),
      .reset   (reset),
      .rd_slot (a_slot),
      .ctl     (b_ctl),
      .wr_slot (b_slot_ff),
      .sample  (b_green_ff),
      .count   (b_count_ff),
      .level   (green_level)
   );

   psa_lane #(
      .MAX_PIXELS  (MAX_PIXELS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_lane_blue (
      .clock   (clock),
      .reset   (reset),
      .rd_slot (a_slot),
      .ctl     (b_ctl),
      .wr_slot (b_slot_ff),
      .sample  (b_blue_ff),
      .count   (b_count_ff),
      .level   (blue_level)
   );

   // Carry item info alongside the lanes.
   assign b_meta.index     = b_index_ff;
   assign b_meta.samples   = TAKEN_W'(b_count_ff);
   assign b_meta.saturated = b_drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) begin
            mvalid_ff[i] <= 1'b0;
         end
      end else begin
         mvalid_ff[0] <= b_valid_ff;
         for (int i = 1; i < LANE_LAT; i++) begin
            mvalid_ff[i] <= mvalid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[0] <= b_meta;
      for (int i = 1; i < LANE_LAT; i++) begin
         meta_ff[i] <= meta_ff[i-1];
      end
   end

   psa_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .push        (mvalid_ff[LANE_LAT-1]),
      .meta        (meta_ff[LANE_LAT-1]),
      .red_level   (red_level),
      .green_level (green_level),
      .blue_level  (blue_level),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_item    (out_item)
   );

   assign rsp_tdata = {5'd0, out_item.samples, out_item.blue, out_item.green,
                       out_item.red, out_item.index};
   assign rsp_tuser = out_item.saturated;

   a_credit_bound : assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CRED_W'(FIFO_DEPTH))
      else $error("outstanding item count exceeds queue depth");

   a_restart_count : assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser[1]) |=> (count_ff == CNT_W'(1)))
      else $error("restart did not reset the frame count to one");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("frame count beyond its maximum");

   a_drop_full : assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> (count_ff == CNT_MAX))
      else $error("frame dropped while the count is not full");

   a_result_owed : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (credit_ff != '0))
      else $error("result offered with no item outstanding");

endmodule

[hw/rtl/psa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module psa_ram import psa_pkg::*; #(
   parameter int WIDTH = SUM_W,
   parameter int DEPTH = DEF_MAX_PIXELS
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents on a same-address write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/psa_div.sv]
// Pipelined restoring divider: 255 * sum / (4096 * n), clamped to an 8-bit level; sums of zero or less give zero.
module psa_div import psa_pkg::*; #(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
   input  logic                                   clock,
   input  logic [SUM_W-1:0]                       sum,
   input  logic [$clog2(MAX_SAMPLES+1)-1:0]       count,
   output logic [LEVEL_W-1:0]                     level
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int DW    = (CNT_W + 20 > 33) ? CNT_W + 20 : 33;

   logic [DW-1:0]      rem_ff  [DIV_LAT];
   logic [DW-1:0]      den_ff  [DIV_LAT];
   logic [LEVEL_W-1:0] quo_ff  [DIV_LAT];
   logic               ovf_ff  [DIV_LAT];
   logic               zero_ff [DIV_LAT];

   logic               pos;
   logic [DW-1:0]      base;

   assign pos  = !sum[SUM_W-1] && (sum != '0);
   assign base = pos ? DW'(sum[SUM_W-2:0]) : '0;

   // Input stage: dividend 255 * sum, divisor n << 12.
   always_ff @(posedge clock) begin
      rem_ff[0]  <= (base << 8) - base;
      den_ff[0]  <= DW'(count) << 12;
      quo_ff[0]  <= '0;
      ovf_ff[0]  <= 1'b0;
      zero_ff[0] <= !pos;
   end

   for (genvar k = 0; k <= LEVEL_W; k++) begin : g_step
      localparam int SH = LEVEL_W - k;
      logic [DW-1:0] cmp;
      logic          ge;

      assign cmp = den_ff[k] << SH;
      assign ge  = rem_ff[k] >= cmp;

      always_ff @(posedge clock) begin
         den_ff[k+1]  <= den_ff[k];
         zero_ff[k+1] <= zero_ff[k];
         if (SH == LEVEL_W) begin
            // Quotient of 256 or more: clamp.
            rem_ff[k+1] <= rem_ff[k];
            quo_ff[k+1] <= quo_ff[k];
            ovf_ff[k+1] <= ge;
         end else begin
            rem_ff[k+1] <= ge ? rem_ff[k] - cmp : rem_ff[k];
            quo_ff[k+1] <= quo_ff[k] | (LEVEL_W'(ge) << SH);
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   assign level = zero_ff[DIV_LAT-1] ? '0 :
                  ovf_ff[DIV_LAT-1]  ? LEVEL_MAX : quo_ff[DIV_LAT-1];

endmodule

[hw/rtl/psa_lane.sv]
// One color lane: per-pixel running sum in RAM, fold with forwarding, level divider.
module psa_lane import psa_pkg::*; #(
   parameter int MAX_PIXELS  = DEF_MAX_PIXELS,
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic [(MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1)-1:0] rd_slot,
   input  fold_ctl_type                                     ctl,
   input  logic [(MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1)-1:0] wr_slot,
   input  logic signed [SAMPLE_W-1:0]                       sample,
   input  logic [$clog2(MAX_SAMPLES+1)-1:0]                 count,
   output logic [LEVEL_W-1:0]                               level
);

   localparam int AW    = MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1;
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

   logic [SUM_W-1:0] rd_data;
   logic [SUM_W-1:0] old_sum;
   logic [SUM_W-1:0] ext_sample;
   logic [SUM_W-1:0] new_sum;
   logic             wr_en;

   logic             fwd_valid_ff;
   logic [AW-1:0]    fwd_slot_ff;
   logic [SUM_W-1:0] fwd_sum_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] count_ff;

   psa_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_PIXELS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_slot),
      .wr_data (new_sum),
      .rd_addr (rd_slot),
      .rd_data (rd_data)
   );

   // The RAM read missed the write made in the same cycle; take it from here.
   assign old_sum    = (fwd_valid_ff && fwd_slot_ff == wr_slot) ? fwd_sum_ff : rd_data;
   assign ext_sample = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
   assign new_sum    = ctl.first ? ext_sample :
                       ctl.drop  ? old_sum    : old_sum + ext_sample;
   assign wr_en      = ctl.valid && !ctl.drop;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (wr_en) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_slot_ff <= wr_slot;
         fwd_sum_ff  <= new_sum;
      end
      sum_ff   <= new_sum;
      count_ff <= count;
   end

   psa_div #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_div (
      .clock (clock),
      .sum   (sum_ff),
      .count (count_ff),
      .level (level)
   );

endmodule

[hw/rtl/psa_merge.sv]
// Merge stage: joins the three lane levels with the item info and queues results.
module psa_merge import psa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  psa_meta_type       meta,
   input  logic [LEVEL_W-1:0] red_level,
   input  logic [LEVEL_W-1:0] green_level,
   input  logic [LEVEL_W-1:0] blue_level,
   output logic               out_valid,
   input  logic               out_ready,
   output rsp_item_type       out_item
);

   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

   rsp_item_type      queue_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              pop;
   rsp_item_type      joined;

   assign joined.index     = meta.index;
   assign joined.red       = red_level;
   assign joined.green     = green_level;
   assign joined.blue      = blue_level;
   assign joined.samples   = meta.samples;
   assign joined.saturated = meta.saturated;

   assign out_valid = fill_ff != '0;
   assign pop       = out_valid && out_ready;
   assign out_item  = queue_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign fill_in   = fill_ff + FILL_W'(push) - FILL_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= joined;
      end
   end

endmodule

[bench/tb_top.sv]
// Testbench for the progressive sample averager: directed and random pixel frames checked against a predictor.
`timescale 1ns / 100ps
module tb_top;
   import psa_pkg::*;

   localparam longint ONE_Q12       = 4096;
   localparam int     SETTLE_CYCLES = 40;
   localparam int     STALL_CYCLES  = 150;
   localparam int     TARGET_PIXELS = 1650;
   localparam int     REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [INDEX_W-1:0]       index;
      logic                     frame_start;
      logic                     restart;
      logic [2:0][SAMPLE_W-1:0] color;   // blue, green, red from the top
   } pixel_item_type;

   class average_scoreboard;
      logic signed [SUM_W-1:0] sums [3][DEF_MAX_PIXELS];
      logic [TAKEN_W-1:0]      frames = '0;
      bit                      first_frame = 1'b0;
      bit                      drop_frame = 1'b0;
      rsp_item_type            expected_averages[$];
      int                      mismatches = 0;

      function logic [LEVEL_W-1:0] level(logic signed [SUM_W-1:0] sum);
         longint quotient;
         if (sum <= 0)
            return '0;
         quotient = (longint'(sum) * longint'(LEVEL_MAX)) / (longint'(frames) * ONE_Q12);
         return (quotient > longint'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(quotient);
      endfunction

      function void note_pixel(pixel_item_type p);
         rsp_item_type            want;
         logic signed [SUM_W-1:0] sample;
         logic [LEVEL_W-1:0]      levels [3];
         int                      slot;
         slot = int'(p.index) % DEF_MAX_PIXELS;
         // a pixel with no frame open behaves like a restart
         if (p.frame_start || p.restart || frames == 0) begin
            if (p.restart || frames == 0) begin
               frames      = 1;
               first_frame = 1'b1;
               drop_frame  = 1'b0;
            end else if (frames < DEF_MAX_SAMPLES) begin
               frames++;
               first_frame = 1'b0;
               drop_frame  = 1'b0;
            end else begin
               first_frame = 1'b0;
               drop_frame  = 1'b1;
            end
         end
         for (int c = 0; c < 3; c++) begin
            sample = $signed(p.color[c]);
            // sums wrap within their width
            if (!drop_frame)
               sums[c][slot] = first_frame ? sample : sums[c][slot] + sample;
            levels[c] = level(sums[c][slot]);
         end
         want.index     = p.index;
         want.red       = levels[0];
         want.green     = levels[1];
         want.blue      = levels[2];
         want.samples   = frames;
         want.saturated = drop_frame;
         expected_averages.push_back(want);
      endfunction

      function void complain(string what, rsp_item_type want, rsp_item_type got);
         if (mismatches < REPORT_LIMIT)
            $display("%0t %s: expected idx %0d rgb %0d/%0d/%0d n %0d sat %0d, got idx %0d rgb %0d/%0d/%0d n %0d sat %0d",
                     $time, what, want.index, want.red, want.green, want.blue, want.samples,
                     want.saturated, got.index, got.red, got.green, got.blue, got.samples,
                     got.saturated);
         mismatches++;
      endfunction

      function void check_average(rsp_item_type got);
         rsp_item_type want;
         if (expected_averages.size() == 0) begin
            complain("result with nothing outstanding", '0, got);
            return;
         end
         want = expected_averages.pop_front();
         if (got.index !== want.index || got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.samples !== want.samples ||
             got.saturated !== want.saturated)
            complain("average mismatch", want, got);
      endfunction

      function int pending();
         return expected_averages.size();
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // pixel_index, sample_red, sample_green, sample_blue
   logic [1:0]  req_tuser  = '0;   // frame_start, restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // out_index, red_level, green_level, blue_level,
                                   // samples_taken, zero fill
   logic [0:0]  rsp_tuser;         // saturated

   average_scoreboard board = new;
   bit send_steady = 1'b0;
   bit take_steady = 1'b0;
   int pixels_sent = 0;

   progressive_sample_averager_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [INDEX_W-1:0] draw_index();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return INDEX_W'($urandom);
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2, 3: return SAMPLE_W'($urandom_range(0, ONE_Q12));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_pixel(pixel_item_type p);
      int gap;
      if ($urandom_range(0, 39) == 0)
         send_steady = !send_steady;
      gap = send_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p.color, p.index};
      req_tuser  <= {p.restart, p.frame_start};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_pixel(p);
      pixels_sent++;
   endtask

   task automatic push_pixel(logic [INDEX_W-1:0] index, bit frame_start, bit restart,
                             logic [SAMPLE_W-1:0] red, logic [SAMPLE_W-1:0] green,
                             logic [SAMPLE_W-1:0] blue);
      pixel_item_type p;
      p.index       = index;
      p.frame_start = frame_start;
      p.restart     = restart;
      p.color       = {blue, green, red};
      send_pixel(p);
   endtask

   // hold the input until every outstanding result has been taken
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // one restart frame that writes a pool of pixels, then frames that revisit only those
   task automatic run_episode();
      logic [INDEX_W-1:0] pool[$];
      logic [INDEX_W-1:0] index;
      int                 pool_size;
      int                 frame_count;
      int                 per_frame;
      if ($urandom_range(0, 5) == 0)
         drain_results();
      pool_size   = $urandom_range(1, 6);
      frame_count = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      for (int i = 0; i < pool_size; i++) begin
         index = draw_index();
         pool.push_back(index);
         push_pixel(index, i == 0 && $urandom_range(0, 1) == 1, i == 0,
                    draw_sample(), draw_sample(), draw_sample());
      end
      for (int f = 0; f < frame_count; f++) begin
         per_frame = $urandom_range(1, 8);
         for (int k = 0; k < per_frame; k++)
            push_pixel(pool[$urandom_range(0, pool.size() - 1)], k == 0, 1'b0,
                       draw_sample(), draw_sample(), draw_sample());
      end
   endtask

   initial begin : stimulus
      logic [INDEX_W-1:0] hot;
      logic [INDEX_W-1:0] cold;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // no frame open yet: the first pixel starts sample one
      push_pixel(16'h0000, 0, 0, 16'h7FFF, 16'h8000, 16'h1000);
      push_pixel(16'hFFFF, 0, 0, 16'h1000, 16'h0000, 16'hFFFF);
      push_pixel(16'hA5A5, 0, 0, 16'h0800, 16'h0FFF, 16'h1001);
      push_pixel(16'h5A5A, 0, 0, 16'h0001, 16'h7FFF, 16'h8000);
      push_pixel(16'h0000, 1, 0, 16'h7FFF, 16'h8000, 16'h1000);
      push_pixel(16'hFFFF, 0, 0, 16'h1000, 16'h1000, 16'h0001);
      push_pixel(16'hA5A5, 0, 0, 16'h0800, 16'hF001, 16'h0FFF);
      // same pixel twice in one frame adds twice
      push_pixel(16'hA5A5, 0, 0, 16'h7FFF, 16'h7FFF, 16'h8000);
      push_pixel(16'h5A5A, 1, 0, 16'h1000, 16'h8000, 16'h7FFF);
      push_pixel(16'h0000, 0, 0, 16'h0000, 16'h1000, 16'h2000);
      // restart alone opens a new first frame
      push_pixel(16'h5A5A, 0, 1, 16'h1000, 16'h0800, 16'h0400);
      push_pixel(16'hFFFF, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      push_pixel(16'h5A5A, 1, 0, 16'h8000, 16'h1000, 16'h0000);
      push_pixel(16'hFFFF, 0, 0, 16'hFFFF, 16'h0FFF, 16'h1000);
      push_pixel(16'hFFFF, 1, 1, 16'h0C00, 16'hF000, 16'h7FFF);
      push_pixel(16'hFFFF, 1, 0, 16'h0400, 16'h1000, 16'h8000);
      push_pixel(16'hFFFF, 0, 0, 16'h0001, 16'h0002, 16'h0003);
      drain_results();

      while (pixels_sent < 350)
         run_episode();

      // fill the sample count: a first frame of two pixels, then one pixel per frame up to the limit
      drain_results();
      hot  = draw_index();
      cold = hot ^ 16'h8001;
      push_pixel(hot, 1, 1, 16'h7FFF, 16'h8000, draw_sample());
      push_pixel(cold, 0, 0, draw_sample(), draw_sample(), draw_sample());
      for (int f = 1; f < DEF_MAX_SAMPLES; f++)
         push_pixel(hot, 1, 0, 16'h7FFF, 16'h8000, draw_sample());
      // push the sums past their width inside the last counted frame
      repeat (2) push_pixel(hot, 0, 0, 16'h7FFF, 16'h8000, draw_sample());
      // frames past the limit are dropped
      for (int f = 0; f < 4; f++) begin
         push_pixel(hot, 1, 0, draw_sample(), draw_sample(), draw_sample());
         push_pixel(cold, 0, 0, draw_sample(), draw_sample(), draw_sample());
      end

      while (pixels_sent < TARGET_PIXELS)
         run_episode();

      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : take_results
      rsp_item_type got;
      int           gap;
      int           taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // long hold-off so the result queue fills and the input stalls
         if (taken == 200 || taken == 1100) begin
            rsp_tready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
         end
         if ($urandom_range(0, 39) == 0)
            take_steady = !take_steady;
         gap = take_steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         {got.samples, got.blue, got.green, got.red, got.index} = rsp_tdata[50:0];
         got.saturated = rsp_tuser[0];
         board.check_average(got);
         taken++;
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/psa_pkg.sv
hw/rtl/psa_ram.sv
hw/rtl/psa_div.sv
hw/rtl/psa_lane.sv
hw/rtl/psa_merge.sv
hw/rtl/progressive_sample_averager_top.sv
bench/tb_top.sv
